/* src/touch_key_change_to_note_events_unit_defines.svh */
// Assertion macros for the touch key event unit.
// Used by the top level only; depends on i_clk and i_rst_n in the using scope.
`ifndef TOUCH_KEY_CHANGE_TO_NOTE_EVENTS_UNIT_DEFINES_SVH
`define TOUCH_KEY_CHANGE_TO_NOTE_EVENTS_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TKNE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TKNE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/tkne_pkg.sv */
// Shared types and constants for the touch key event unit.
// No dependencies; used by the controller, the datapath and the top level.
package tkne_pkg;

    localparam int KEYS_PER_DEVICE_DEF = 6;
    localparam int DEVICE_COUNT_DEF    = 2;

    localparam int SWITCH_W  = 6;
    localparam int OCTAVE_W  = 3;
    localparam int KEY_OUT_W = 4;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;

    localparam logic [VEL_W-1:0]  VEL_ON   = 7'h7F;
    localparam logic [VEL_W-1:0]  VEL_OFF  = 7'h40;
    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

    // Output tdata layout, lowest bit first: key_index, note_number, velocity.
    localparam int M_DATA_W = 24;
    localparam int S_DATA_W = 8;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;   // take the input word and latch its change mask
        logic emit;   // move the next pending event into the output register
    } t_cmd;

    typedef struct packed {
        logic change_any;    // the offered word is in range and changes a key
        logic pending_last;  // exactly one event is still pending
        logic out_free;      // the output register can take an event this cycle
    } t_status;

endpackage

/* src/tkne_ctrl.sv */
// Controller state machine of the touch key event unit.
// Depends on tkne_pkg for the state, command and status types.
module tkne_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  tkne_pkg::t_status i_status,
    output tkne_pkg::t_cmd    o_cmd
);

    tkne_pkg::t_state r_state;
    tkne_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkne_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tkne_pkg::ST_IDLE: begin
                if (i_s_tvalid && i_status.change_any) begin
                    n_state = tkne_pkg::ST_EMIT;
                end
            end
            tkne_pkg::ST_EMIT: begin
                if (i_status.out_free && i_status.pending_last) begin
                    n_state = tkne_pkg::ST_IDLE;
                end
            end
            default: n_state = tkne_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tkne_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            tkne_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* src/tkne_dpath.sv */
// Datapath of the touch key event unit: stored words, change mask, event build.
// Depends on tkne_pkg; driven by tkne_ctrl through t_cmd and t_status.
module tkne_dpath #(
    parameter int KEYS_PER_DEVICE = tkne_pkg::KEYS_PER_DEVICE_DEF,
    parameter int DEVICE_COUNT    = tkne_pkg::DEVICE_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [tkne_pkg::S_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_cfg_valid,
    input  logic [tkne_pkg::OCTAVE_W-1:0]    i_cfg_data,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [tkne_pkg::M_DATA_W-1:0]    o_m_tdata,
    output logic                             o_m_tuser,
    output logic                             o_m_tlast,
    input  tkne_pkg::t_cmd                   i_cmd,
    output tkne_pkg::t_status                o_status
);

    localparam int SCAN_W = (KEYS_PER_DEVICE < tkne_pkg::SWITCH_W) ?
                            KEYS_PER_DEVICE : tkne_pkg::SWITCH_W;
    localparam int IDX_W  = (SCAN_W > 1) ? $clog2(SCAN_W) : 1;
    localparam int DEV_AW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam int KEY_W  = $clog2(KEYS_PER_DEVICE + tkne_pkg::SWITCH_W + 1);
    localparam int SUM_W  = ((KEY_W > tkne_pkg::NOTE_W) ? KEY_W : tkne_pkg::NOTE_W) + 1;

    logic [tkne_pkg::SWITCH_W-1:0] r_prev [DEVICE_COUNT];
    logic [tkne_pkg::OCTAVE_W-1:0] r_octave;
    logic [SCAN_W-1:0]             r_pending;
    logic                          r_dev;

    logic                          r_m_valid;
    logic [tkne_pkg::KEY_OUT_W-1:0] r_key;
    logic [tkne_pkg::NOTE_W-1:0]    r_note;
    logic                           r_on;
    logic                           r_last;

    logic [tkne_pkg::SWITCH_W-1:0] now_word;
    logic [DEV_AW-1:0]             dev_addr;
    logic                          in_range;
    logic [tkne_pkg::SWITCH_W-1:0] prev_sel;
    logic [SCAN_W-1:0]             changed;
    logic [SCAN_W-1:0]             low_bit;
    logic [IDX_W-1:0]              low_idx;
    logic [KEY_W-1:0]              key_full;
    logic [tkne_pkg::NOTE_W-1:0]   oct12;
    logic [SUM_W-1:0]              note_sum;
    logic [tkne_pkg::NOTE_W-1:0]   note_sat;
    logic                          out_free;

    assign now_word = i_s_tdata[tkne_pkg::SWITCH_W-1:0];
    assign dev_addr = DEV_AW'(i_s_tuser);
    assign in_range = (DEVICE_COUNT > 1) || !i_s_tuser;
    assign prev_sel = r_prev[dev_addr];
    assign changed  = prev_sel[SCAN_W-1:0] ^ now_word[SCAN_W-1:0];

    // Lowest pending key goes out first.
    assign low_bit = r_pending & (~r_pending + SCAN_W'(1));

    always_comb begin
        low_idx = '0;
        for (int b = SCAN_W - 1; b >= 0; b--) begin
            if (r_pending[b]) begin
                low_idx = IDX_W'(b);
            end
        end
    end

    assign key_full = (r_dev ? KEY_W'(KEYS_PER_DEVICE) : '0) + KEY_W'(low_idx);
    assign oct12    = tkne_pkg::NOTE_W'({r_octave, 3'b000}) +
                      tkne_pkg::NOTE_W'({r_octave, 2'b00});
    assign note_sum = SUM_W'(key_full) + SUM_W'(oct12);
    assign note_sat = (note_sum > SUM_W'(tkne_pkg::NOTE_MAX)) ?
                      tkne_pkg::NOTE_MAX : note_sum[tkne_pkg::NOTE_W-1:0];

    assign out_free = !r_m_valid || i_m_tready;

    assign o_status.change_any   = in_range && (changed != '0);
    assign o_status.pending_last = (r_pending & ~low_bit) == '0;
    assign o_status.out_free     = out_free;

    // The stored word already holds the new state of the device being scanned.
    function automatic logic [SCAN_W-1:0] stored_now_bits();
        logic [tkne_pkg::SWITCH_W-1:0] w;
        w = r_prev[DEV_AW'(r_dev)];
        return w[SCAN_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_prev[d] <= '0;
            end
            r_octave  <= '0;
            r_pending <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_octave <= i_cfg_data;
            end
            if (i_cmd.load && in_range) begin
                r_prev[dev_addr] <= now_word;
                r_pending        <= changed;
            end else if (i_cmd.emit) begin
                r_pending <= r_pending & ~low_bit;
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dev <= i_s_tuser;
        end
        if (i_cmd.emit) begin
            r_key  <= key_full[tkne_pkg::KEY_OUT_W-1:0];
            r_note <= note_sat;
            r_on   <= |(low_bit & stored_now_bits());
            r_last <= (r_pending & ~low_bit) == '0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b000000,
                         (r_on ? tkne_pkg::VEL_ON : tkne_pkg::VEL_OFF),
                         r_note, r_key};
    assign o_m_tuser  = r_on;
    assign o_m_tlast  = r_last;

endmodule

/* src/touch_key_change_to_note_events_unit.sv */
// Touch key event unit, top level: ties the controller to the datapath.
// Depends on tkne_pkg, tkne_ctrl, tkne_dpath and the assertion macro header.
//
// This block turns switch words from touch sensor devices into note events.
// Each input transfer carries one device's switch word; the word is compared
// with the word last seen from that device, and every key that changed
// produces one output transfer, lowest key first, with tlast on the final
// one. A press gives a note-on at velocity 127, a release a note-off at
// velocity 64, and the note number is the global key index plus twelve
// semitones per octave step (saturating at 127). A word with no change gives
// no output at all, and a word from a device beyond the configured count is
// dropped. A word is accepted while the block is idle; the scan then hands one
// event a cycle into the single output register while that register is
// free, so output back-pressure holds the scan. The next word is taken as
// soon as the last event sits in the output register, even if that event has
// not been transferred yet. The stored words clear at reset. The octave
// register is written over its own channel, which is always ready, and should
// only be written while the block is idle.
`include "touch_key_change_to_note_events_unit_defines.svh"

module touch_key_change_to_note_events_unit #(
    parameter int KEYS_PER_DEVICE = tkne_pkg::KEYS_PER_DEVICE_DEF,
    parameter int DEVICE_COUNT    = tkne_pkg::DEVICE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tkne_pkg::S_DATA_W-1:0] i_s_tdata,  // [5:0] switch_bits, [7:6] zero
    input  logic                          i_s_tuser,  // [0] device_index
    // Octave register write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tkne_pkg::OCTAVE_W-1:0] i_cfg_data,
    // Output stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tkne_pkg::M_DATA_W-1:0] o_m_tdata,  // [3:0] key_index,
                                                      // [10:4] note_number,
                                                      // [17:11] velocity, [23:18] zero
    output logic                          o_m_tuser,  // [0] note_on
    output logic                          o_m_tlast   // last event of the input word
);

    tkne_pkg::t_cmd    cmd;
    tkne_pkg::t_status status;

    // Output fields split out for the checks below.
    logic [tkne_pkg::KEY_OUT_W-1:0] m_key;
    logic [tkne_pkg::NOTE_W-1:0]    m_note;
    logic [tkne_pkg::VEL_W-1:0]     m_velocity;
    logic [tkne_pkg::VEL_W-1:0]     vel_expect;

    // The register is a plain flop, so a write always completes at once.
    assign o_cfg_ready = 1'b1;

    tkne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tkne_dpath #(
        .KEYS_PER_DEVICE (KEYS_PER_DEVICE),
        .DEVICE_COUNT    (DEVICE_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    assign m_key      = o_m_tdata[3:0];
    assign m_note     = o_m_tdata[10:4];
    assign m_velocity = o_m_tdata[17:11];
    assign vel_expect = o_m_tuser ? tkne_pkg::VEL_ON : tkne_pkg::VEL_OFF;

    // While a non-final event is shown, more events are pending, so no word is taken.
    `TKNE_ASSERT_IMP(a_busy_mid_run, o_m_tvalid && !o_m_tlast, !o_s_tready, "input ready mid run")
    // After a non-final event is transferred the next event is shown at once.
    `TKNE_ASSERT_NXT(a_run_continues, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid, "run gap")
    // Velocity follows the note-on flag.
    `TKNE_ASSERT_IMP(a_velocity_kind, o_m_tvalid, m_velocity == vel_expect, "velocity mismatch")
    // The note never lies below the reported key index.
    `TKNE_ASSERT_IMP(a_note_ge_key, o_m_tvalid, m_note >= {3'b000, m_key}, "note below key")

endmodule
